// ===== src/snsconv_pkg.sv =====
// Shared types and constants for the sensor reading converter.
// Used by every module under src; no dependencies.
`default_nettype none

package snsconv_pkg;

  // Request kinds carried in tuser
  localparam logic [2:0] REQ_TEMP_RD  = 3'd0;
  localparam logic [2:0] REQ_FAN_RD   = 3'd1;
  localparam logic [2:0] REQ_LIMIT_RD = 3'd2;
  localparam logic [2:0] REQ_LIMIT_WR = 3'd3;
  localparam logic [2:0] REQ_TEMP_WR  = 3'd4;

  // Divider width: dividend, divisor and quotient all fit in this many bits
  localparam int unsigned QW = 22;

  localparam logic [QW-1:0]      FAN_SCALE   = 22'd1350000;
  localparam logic [12:0]        COUNT_MAX   = 13'h1fff;
  // Above this RPM the rounded count is zero
  localparam logic signed [32:0] RPM_ZERO_LIM = 33'sd2700000;
  localparam logic signed [32:0] MDEG_MIN    = -33'sd128000;
  localparam logic signed [32:0] MDEG_MAX    = 33'sd127000;
  localparam logic [QW-1:0]      MDEG_DIV    = 22'd1000;
  localparam logic [QW-1:0]      MDEG_HALF   = 22'd500;
  localparam logic signed [QW-1:0] TEMP_STEP = 22'sd125;

  // Sideband that rides along the divider chain
  typedef struct packed {
    logic [2:0]    req;
    logic          use_q;
    logic          neg;
    logic [QW-1:0] fixed;
  } side_t;

  // One divider stage: partial remainder, dividend/quotient shifter, divisor
  typedef struct packed {
    logic          vld;
    logic [QW-1:0] rem;
    logic [QW-1:0] nq;
    logic [QW-1:0] den;
    side_t         side;
  } stage_t;

endpackage

`default_nettype wire

// ===== src/sensor_reading_converter.sv =====
// Top level of the sensor reading converter: front decode, divider cell row,
// output register. Depends on snsconv_pkg, snsconv_prep, snsconv_cell, snsconv_out.
//
//   channel  direction  payload
//   s_axis   in         tuser: req_type; tdata: raw_high, raw_low, value_in
//   m_axis   out        tdata: value_out, byte_low, byte_high
//
// The pipe is one decode stage, 22 divide cells (one quotient bit each) and
// the output register. A new transfer is taken every cycle unless the row holds.
// The whole row moves together; it holds while the output register is full
// and m_axis_tready is low. Reset clears all valid flags.
`default_nettype none

module sensor_reading_converter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] raw_high, [15:8] raw_low, [48:16] value_in, [55:49] zero
  input  wire logic [55:0] s_axis_tdata,
  // [2:0] req_type
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [21:0] value_out, [29:22] byte_low, [37:30] byte_high, [39:38] zero
  output logic [39:0]      m_axis_tdata
);

  localparam int unsigned NCELL = snsconv_pkg::QW;

  logic                 adv;
  snsconv_pkg::stage_t  chain [NCELL+1];
  logic [21:0]          value_out;
  logic [7:0]           byte_low, byte_high;

  // Advance everything unless a result sits unclaimed
  assign adv           = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = adv;

  snsconv_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .vld_i      (s_axis_tvalid),
    .req_i      (s_axis_tuser),
    .raw_high_i (s_axis_tdata[7:0]),
    .raw_low_i  (s_axis_tdata[15:8]),
    .value_in_i ($signed(s_axis_tdata[48:16])),
    .stage_o    (chain[0])
  );

  // Row of divide cells, most significant quotient bit first
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    snsconv_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .stage_i (chain[g]),
      .stage_o (chain[g+1])
    );
  end

  snsconv_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .stage_i     (chain[NCELL]),
    .vld_o       (m_axis_tvalid),
    .value_out_o (value_out),
    .byte_low_o  (byte_low),
    .byte_high_o (byte_high)
  );

  assign m_axis_tdata = {2'b00, byte_high, byte_low, value_out};

endmodule

`default_nettype wire

// ===== src/snsconv_prep.sv =====
// Front stage: decodes the request and sets up dividend and divisor or a fixed answer.
// Depends on snsconv_pkg.
`default_nettype none

module snsconv_prep (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                adv_i,
  input  wire logic                vld_i,
  input  wire logic [2:0]          req_i,
  input  wire logic [7:0]          raw_high_i,
  input  wire logic [7:0]          raw_low_i,
  input  wire logic signed [32:0]  value_in_i,
  output snsconv_pkg::stage_t      stage_o
);

  logic [12:0]                     cnt;
  logic signed [10:0]              t11;
  logic signed [snsconv_pkg::QW-1:0] temp_mdeg;
  logic signed [32:0]              clamped;
  logic signed [32:0]              clamped_neg;
  logic [16:0]                     mag;
  logic [snsconv_pkg::QW-1:0]      num_d, den_d, num_q, den_q;
  snsconv_pkg::side_t              side_d, side_q;
  logic                            vld_q;

  // Pick the count layout of the register pair
  assign cnt = (req_i == snsconv_pkg::REQ_FAN_RD) ? {raw_high_i, raw_low_i[7:3]}
                                                  : {raw_high_i[7:3], raw_low_i};

  // Temperature read: 11-bit signed eighths of a degree
  assign t11       = {raw_high_i, raw_low_i[7:5]};
  assign temp_mdeg = t11 * snsconv_pkg::TEMP_STEP;

  // Temperature write: clamp and take magnitude
  always_comb begin
    if (value_in_i < snsconv_pkg::MDEG_MIN) begin
      clamped = snsconv_pkg::MDEG_MIN;
    end else if (value_in_i > snsconv_pkg::MDEG_MAX) begin
      clamped = snsconv_pkg::MDEG_MAX;
    end else begin
      clamped = value_in_i;
    end
  end
  assign clamped_neg = -clamped;
  assign mag = clamped[32] ? clamped_neg[16:0] : clamped[16:0];

  // Decode the request into divide operands or a fixed answer
  always_comb begin
    num_d        = '0;
    den_d        = snsconv_pkg::QW'(1);
    side_d       = '0;
    side_d.req   = req_i;
    unique case (req_i)
      snsconv_pkg::REQ_TEMP_RD: begin
        side_d.fixed = temp_mdeg;
      end
      snsconv_pkg::REQ_FAN_RD, snsconv_pkg::REQ_LIMIT_RD: begin
        if (cnt == snsconv_pkg::COUNT_MAX) begin
          side_d.fixed = '0;
        end else if (cnt == '0) begin
          side_d.fixed = (req_i == snsconv_pkg::REQ_LIMIT_RD) ? snsconv_pkg::FAN_SCALE : '0;
        end else begin
          side_d.use_q = 1'b1;
          den_d        = snsconv_pkg::QW'(cnt);
          num_d        = snsconv_pkg::FAN_SCALE + snsconv_pkg::QW'(cnt[12:1]);
        end
      end
      snsconv_pkg::REQ_LIMIT_WR: begin
        if (value_in_i[32] || value_in_i == '0) begin
          side_d.fixed = snsconv_pkg::QW'(snsconv_pkg::COUNT_MAX);
        end else if (value_in_i > snsconv_pkg::RPM_ZERO_LIM) begin
          side_d.fixed = '0;
        end else begin
          side_d.use_q = 1'b1;
          den_d        = value_in_i[snsconv_pkg::QW-1:0];
          num_d        = snsconv_pkg::FAN_SCALE + {1'b0, value_in_i[snsconv_pkg::QW-1:1]};
        end
      end
      snsconv_pkg::REQ_TEMP_WR: begin
        side_d.use_q = 1'b1;
        side_d.neg   = clamped[32];
        den_d        = snsconv_pkg::MDEG_DIV;
        num_d        = snsconv_pkg::QW'(mag) + snsconv_pkg::MDEG_HALF;
      end
      default: begin
        side_d.fixed = '0;
      end
    endcase
  end

  // Clear valid under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  // Capture operands on advance
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      num_q  <= num_d;
      den_q  <= den_d;
      side_q <= side_d;
    end
  end

  assign stage_o.vld  = vld_q;
  assign stage_o.rem  = '0;
  assign stage_o.nq   = num_q;
  assign stage_o.den  = den_q;
  assign stage_o.side = side_q;

endmodule

`default_nettype wire

// ===== src/snsconv_cell.sv =====
// One restoring-divide cell: resolves one quotient bit per item.
// Depends on snsconv_pkg.
`default_nettype none

module snsconv_cell (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 adv_i,
  input  wire snsconv_pkg::stage_t  stage_i,
  output snsconv_pkg::stage_t       stage_o
);

  logic [snsconv_pkg::QW:0]   trial;
  logic [snsconv_pkg::QW+1:0] diff;
  logic                       ge;
  logic                       vld_q;
  logic [snsconv_pkg::QW-1:0] rem_q, nq_q, den_q;
  snsconv_pkg::side_t         side_q;

  // Shift in the next dividend bit and try the subtract
  assign trial = {stage_i.rem, stage_i.nq[snsconv_pkg::QW-1]};
  assign diff  = {1'b0, trial} - {2'b00, stage_i.den};
  assign ge    = ~diff[snsconv_pkg::QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= stage_i.vld;
    end
  end

  // Keep the difference on a fit, else the shifted remainder
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q  <= ge ? diff[snsconv_pkg::QW-1:0] : trial[snsconv_pkg::QW-1:0];
      nq_q   <= {stage_i.nq[snsconv_pkg::QW-2:0], ge};
      den_q  <= stage_i.den;
      side_q <= stage_i.side;
    end
  end

  assign stage_o.vld  = vld_q;
  assign stage_o.rem  = rem_q;
  assign stage_o.nq   = nq_q;
  assign stage_o.den  = den_q;
  assign stage_o.side = side_q;

endmodule

`default_nettype wire

// ===== src/snsconv_out.sv =====
// Output stage: formats the quotient into result fields and registers them.
// Depends on snsconv_pkg.
`default_nettype none

module snsconv_out (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 adv_i,
  input  wire snsconv_pkg::stage_t  stage_i,
  output logic                      vld_o,
  output logic [21:0]               value_out_o,
  output logic [7:0]                byte_low_o,
  output logic [7:0]                byte_high_o
);

  logic [snsconv_pkg::QW-1:0] q;
  logic [12:0]                cnt;
  logic [7:0]                 tbyte;
  logic [21:0]                value_d, value_q;
  logic [7:0]                 blo_d, blo_q, bhi_d, bhi_q;
  logic                       vld_q;

  assign q = stage_i.nq;

  // Saturate the limit count, or take the fixed one
  always_comb begin
    if (!stage_i.side.use_q) begin
      cnt = stage_i.side.fixed[12:0];
    end else if (q > snsconv_pkg::QW'(snsconv_pkg::COUNT_MAX)) begin
      cnt = snsconv_pkg::COUNT_MAX;
    end else begin
      cnt = q[12:0];
    end
  end

  // Restore the sign of the rounded degree count
  assign tbyte = stage_i.side.neg ? (8'd0 - q[7:0]) : q[7:0];

  always_comb begin
    value_d = '0;
    blo_d   = '0;
    bhi_d   = '0;
    unique case (stage_i.side.req)
      snsconv_pkg::REQ_TEMP_RD: begin
        value_d = stage_i.side.fixed;
      end
      snsconv_pkg::REQ_FAN_RD, snsconv_pkg::REQ_LIMIT_RD: begin
        value_d = stage_i.side.use_q ? q : stage_i.side.fixed;
      end
      snsconv_pkg::REQ_LIMIT_WR: begin
        blo_d = cnt[7:0];
        bhi_d = {cnt[12:8], 3'b000};
      end
      snsconv_pkg::REQ_TEMP_WR: begin
        blo_d = tbyte;
      end
      default: begin
        value_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= stage_i.vld;
    end
  end

  // Load the result register when the pipe advances
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      value_q <= value_d;
      blo_q   <= blo_d;
      bhi_q   <= bhi_d;
    end
  end

  assign vld_o       = vld_q;
  assign value_out_o = value_q;
  assign byte_low_o  = blo_q;
  assign byte_high_o = bhi_q;

endmodule

`default_nettype wire
